[src/okl_pkg.sv]
`timescale 1ns / 1ps
// Types and codes shared by the ordered keyed list block.
// No dependencies; compile before all other files of the block.
package okl_pkg;

    localparam int KEY_W  = 16;
    localparam int DATA_W = 32;
    localparam int POS_W  = 6;
    localparam int CNT_W  = 7;
    localparam int SLOT_W = KEY_W + DATA_W;

    typedef enum logic [1:0] {
        REQ_APPEND = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_FIND   = 2'd2,
        REQ_READ   = 2'd3
    } t_req_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_BAD_POS   = 2'd3
    } t_status;

    typedef struct packed {
        t_req_kind          req_type;
        logic [KEY_W-1:0]   key;
        logic [DATA_W-1:0]  entry_data;
        logic [POS_W-1:0]   position;
    } t_req_item;

    typedef struct packed {
        t_status            status;
        logic [DATA_W-1:0]  found_data;
        logic [KEY_W-1:0]   found_key;
        logic [CNT_W-1:0]   entry_count;
    } t_rsp_item;

endpackage

[src/okl_ifs.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and responses.
// Depends on okl_pkg.
interface okl_req_if;
    import okl_pkg::*;
    logic      valid;
    logic      ready;
    t_req_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface okl_rsp_if;
    import okl_pkg::*;
    logic      valid;
    logic      ready;
    t_rsp_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[src/ordered_keyed_list.sv]
`timescale 1ns / 1ps
// Ordered keyed list: top level with request sequencer and result register.
// Depends on okl_pkg, okl_req_if, okl_rsp_if and okl_store.
//
// Usage: requests arrive on i_req (append, remove by key, find by key,
// read at position); each request gives exactly one response on o_rsp,
// carrying a status, the entry returned and the entry count afterwards.
// A transfer happens on a channel when valid and ready are both high.
// The block works on one request at a time: i_req.ready is high only when
// no request is in flight and no response waits.
// Handling of each kind, from request transfer to response valid:
//   append, or any request rejected at once (full, bad position,
//   remove/find on an empty list): straight to the response register
//   read at position: one slot read through the storage read port
//   find: slots compared one by one until the first match or the end
//   remove: as find, then entries moved up one place to close the gap
// Every slot read goes through the single read port of the storage, and
// each compare or move has a read state then a use state (S_RD/S_CMP,
// S_SHRD/S_SHWR); that sets the order of steps above.
// Reset (synchronous, active low) empties the list; slot contents are not
// cleared, since no request can reach a slot past the count.
// A stalled receiver holds the response in its register and the block
// takes no new request until that response transfers.
module ordered_keyed_list #(
    parameter int CAPACITY = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    okl_req_if.sink    i_req,
    okl_rsp_if.source  o_rsp
);
    import okl_pkg::*;

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RD   = 6'b000010,
        S_CMP  = 6'b000100,
        S_SHRD = 6'b001000,
        S_SHWR = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [IW-1:0]      r_idx, n_idx;
    t_req_kind          r_kind, n_kind;
    logic [KEY_W-1:0]   r_key, n_key;
    t_status            r_status, n_status;
    logic [DATA_W-1:0]  r_fdata, n_fdata;
    logic [KEY_W-1:0]   r_fkey, n_fkey;

    logic               mem_we;
    logic [IW-1:0]      mem_waddr;
    logic [SLOT_W-1:0]  mem_wdata;
    logic [IW-1:0]      mem_raddr;
    logic [SLOT_W-1:0]  mem_rdata;
    logic [KEY_W-1:0]   rd_key;
    logic [DATA_W-1:0]  rd_data;
    logic [CW-1:0]      idx_p1;
    logic [CW-1:0]      idx_p2;
    logic               req_xfer;

    okl_store #(
        .DEPTH (CAPACITY),
        .AW    (IW),
        .DW    (SLOT_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign rd_key   = mem_rdata[SLOT_W-1:DATA_W];
    assign rd_data  = mem_rdata[DATA_W-1:0];
    assign idx_p1   = CW'(r_idx) + CW'(1);
    assign idx_p2   = CW'(r_idx) + CW'(2);
    assign req_xfer = i_req.valid && i_req.ready;

    // Read the next slot while moving entries up, else the scan slot.
    assign mem_raddr = (r_state == S_SHRD) ? IW'(idx_p1) : r_idx;

    assign i_req.ready                 = (r_state == S_IDLE);
    assign o_rsp.valid                 = (r_state == S_OUT);
    assign o_rsp.payload.status        = r_status;
    assign o_rsp.payload.found_data    = r_fdata;
    assign o_rsp.payload.found_key     = r_fkey;
    assign o_rsp.payload.entry_count   = CNT_W'(r_count);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_kind    = r_kind;
        n_key     = r_key;
        n_status  = r_status;
        n_fdata   = r_fdata;
        n_fkey    = r_fkey;
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = mem_rdata;

        case (r_state)
            S_IDLE: begin
                if (req_xfer) begin
                    n_kind   = i_req.payload.req_type;
                    n_key    = i_req.payload.key;
                    n_status = ST_OK;
                    n_fdata  = '0;
                    n_fkey   = '0;
                    n_idx    = '0;
                    case (i_req.payload.req_type)
                        REQ_APPEND: begin
                            n_state = S_OUT;
                            if (r_count >= CW'(CAPACITY)) begin
                                n_status = ST_FULL;
                            end else begin
                                // Place the new entry at the tail.
                                mem_we    = 1'b1;
                                mem_waddr = IW'(r_count);
                                mem_wdata = {i_req.payload.key, i_req.payload.entry_data};
                                n_count   = r_count + CW'(1);
                            end
                        end
                        REQ_READ: begin
                            if (XW'(i_req.payload.position) >= XW'(r_count)) begin
                                n_status = ST_BAD_POS;
                                n_state  = S_OUT;
                            end else begin
                                n_idx   = IW'(i_req.payload.position);
                                n_state = S_RD;
                            end
                        end
                        REQ_REMOVE, REQ_FIND: begin
                            if (r_count == '0) begin
                                n_status = ST_NOT_FOUND;
                                n_state  = S_OUT;
                            end else begin
                                n_state = S_RD;
                            end
                        end
                        default: begin
                            n_state = S_OUT;
                        end
                    endcase
                end
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (r_kind == REQ_READ) begin
                    n_fdata = rd_data;
                    n_fkey  = rd_key;
                    n_state = S_OUT;
                end else if (rd_key == r_key) begin
                    n_fdata = rd_data;
                    n_fkey  = rd_key;
                    if (r_kind == REQ_REMOVE) begin
                        if (idx_p1 < r_count) begin
                            n_state = S_SHRD;
                        end else begin
                            n_count = r_count - CW'(1);
                            n_state = S_OUT;
                        end
                    end else begin
                        n_state = S_OUT;
                    end
                end else if (idx_p1 >= r_count) begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_OUT;
                end else begin
                    n_idx   = IW'(idx_p1);
                    n_state = S_RD;
                end
            end
            S_SHRD: begin
                n_state = S_SHWR;
            end
            S_SHWR: begin
                // Move the successor up one place, then advance.
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = mem_rdata;
                n_idx     = IW'(idx_p1);
                if (idx_p2 < r_count) begin
                    n_state = S_SHRD;
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_kind   <= n_kind;
        r_key    <= n_key;
        r_status <= n_status;
        r_fdata  <= n_fdata;
        r_fkey   <= n_fkey;
    end
endmodule

[src/okl_store.sv]
`timescale 1ns / 1ps
// Slot storage: one write port, one read port with registered read data.
// Depends on nothing; used by ordered_keyed_list.
module okl_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 48
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[bench/okl_checker.sv]
`timescale 1ns / 1ps
// Response checker for the ordered keyed list: watches both channels.
// Depends on okl_pkg and the okl_req_if / okl_rsp_if interfaces.
module okl_checker #(
    parameter int CAPACITY = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    okl_req_if   i_req,
    okl_rsp_if   i_rsp,
    output int   o_errors,
    output int   o_pending,
    output int   o_checked
);
    import okl_pkg::*;

    // Mirror of the list contents, head at index 0.
    logic [KEY_W-1:0]  mirror_key  [CAPACITY];
    logic [DATA_W-1:0] mirror_data [CAPACITY];
    int unsigned       mirror_len;
    t_rsp_item         awaited_rsp_q[$];
    int                mismatch_cnt;
    int                checked_cnt;

    assign o_errors  = mismatch_cnt;
    assign o_checked = checked_cnt;

    // Apply one request to the mirror and return the response it should give.
    function automatic t_rsp_item apply_request(t_req_item rq);
        t_rsp_item rs;
        int        hit;
        int        i;
        rs   = '0;
        rs.status = ST_OK;
        hit  = -1;
        case (rq.req_type)
            REQ_APPEND: begin
                if (mirror_len >= CAPACITY) begin
                    rs.status = ST_FULL;
                end else begin
                    mirror_key[mirror_len]  = rq.key;
                    mirror_data[mirror_len] = rq.entry_data;
                    mirror_len++;
                end
            end
            REQ_REMOVE, REQ_FIND: begin
                for (i = 0; i < int'(mirror_len); i++) begin
                    if (hit < 0 && mirror_key[i] == rq.key) hit = i;
                end
                if (hit < 0) begin
                    rs.status = ST_NOT_FOUND;
                end else begin
                    rs.found_data = mirror_data[hit];
                    rs.found_key  = mirror_key[hit];
                    if (rq.req_type == REQ_REMOVE) begin
                        // close the gap, keeping arrival order
                        for (i = hit; i + 1 < int'(mirror_len); i++) begin
                            mirror_key[i]  = mirror_key[i + 1];
                            mirror_data[i] = mirror_data[i + 1];
                        end
                        mirror_len--;
                    end
                end
            end
            default: begin
                if (rq.position >= mirror_len) begin
                    rs.status = ST_BAD_POS;
                end else begin
                    rs.found_data = mirror_data[rq.position];
                    rs.found_key  = mirror_key[rq.position];
                end
            end
        endcase
        rs.entry_count = CNT_W'(mirror_len);
        return rs;
    endfunction

    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            mismatch_cnt++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
        end
    endtask

    initial begin
        mismatch_cnt = 0;
        checked_cnt  = 0;
        mirror_len   = 0;
    end

    always @(posedge i_clk) begin
        t_rsp_item want;
        if (!i_rst_n) begin
            mirror_len = 0;
            awaited_rsp_q.delete();
            o_pending <= 0;
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (awaited_rsp_q.size() == 0) begin
                    mismatch_cnt++;
                    $display("%0t: response with none expected, got status %0d data 0x%0h",
                             $time, i_rsp.payload.status, i_rsp.payload.found_data);
                end else begin
                    want = awaited_rsp_q.pop_front();
                    checked_cnt++;
                    check_field("status", 32'(want.status), 32'(i_rsp.payload.status));
                    check_field("found_data", want.found_data, i_rsp.payload.found_data);
                    check_field("found_key", 32'(want.found_key), 32'(i_rsp.payload.found_key));
                    check_field("entry_count", 32'(want.entry_count),
                                32'(i_rsp.payload.entry_count));
                end
            end
            if (i_req.valid && i_req.ready)
                awaited_rsp_q.push_back(apply_request(i_req.payload));
            o_pending <= awaited_rsp_q.size();
        end
    end

endmodule

[bench/ordered_keyed_list_tb.sv]
`timescale 1ns / 1ps
// Testbench top for the ordered keyed list: clock, reset, stimulus, verdict.
// Depends on okl_pkg, the channel interfaces, ordered_keyed_list and okl_checker.
module ordered_keyed_list_tb;
    import okl_pkg::*;

    localparam int CAPACITY      = 64;
    // Watchdog limit; well beyond the slowest legal run.
    localparam int CYCLE_LIMIT   = 1_000_000;
    // Idle time after the final drain, before the verdict.
    localparam int SETTLE_CYCLES = 300;
    localparam int PHASE_ITEMS   = 210;

    logic i_clk;
    logic i_rst_n;

    okl_req_if req_ch ();
    okl_rsp_if rsp_ch ();

    int send_idle_pct = 13;
    int recv_idle_pct = 73;
    int error_cnt;
    int pending_cnt;
    int checked_cnt;
    int kind_cnt [4];
    int cycle_cnt;
    logic [KEY_W-1:0] key_pool [8];

    ordered_keyed_list #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    okl_checker #(
        .CAPACITY(CAPACITY)
    ) i_checker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (req_ch),
        .i_rsp    (rsp_ch),
        .o_errors (error_cnt),
        .o_pending(pending_cnt),
        .o_checked(checked_cnt)
    );

    // 100 MHz clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: drop ready at random, at the rate the current phase sets.
    initial begin
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: stop a hung run.
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Run stopped at the cycle limit with %0d responses outstanding", pending_cnt);
        $display("FAIL");
        $finish;
    end

    function automatic t_req_item make_req(t_req_kind kind, logic [KEY_W-1:0] key,
                                           logic [DATA_W-1:0] data, logic [POS_W-1:0] pos);
        t_req_item it;
        it.req_type   = kind;
        it.key        = key;
        it.entry_data = data;
        it.position   = pos;
        return it;
    endfunction

    // Mostly reuse a small pool of keys so that remove and find often hit,
    // and duplicates pile up; the rest is fully random.
    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(99) < 75) return key_pool[$urandom_range(7)];
        return KEY_W'($urandom);
    endfunction

    // Present one request, idling first at random, and hold it until the transfer.
    task automatic send_req(t_req_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= it;
        kind_cnt[it.req_type]++;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    // Hold off the sender until every outstanding response has transferred.
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_cnt != 0) @(posedge i_clk);
    endtask

    // One random request with the given mix; the remainder are reads.
    task automatic send_mix(int append_pct, int remove_pct, int find_pct);
        t_req_kind kind;
        int        roll;
        roll = $urandom_range(99);
        if (roll < append_pct)                               kind = REQ_APPEND;
        else if (roll < append_pct + remove_pct)             kind = REQ_REMOVE;
        else if (roll < append_pct + remove_pct + find_pct)  kind = REQ_FIND;
        else                                                 kind = REQ_READ;
        send_req(make_req(kind, pick_key(), DATA_W'($urandom),
                          ($urandom_range(2) == 0) ? POS_W'($urandom)
                                                   : POS_W'($urandom_range(15))));
    endtask

    initial begin
        int phase;
        int phase_items;
        int seg_mode;
        int seg_len;

        req_ch.valid   <= 1'b0;
        req_ch.payload <= '0;
        i_rst_n        <= 1'b0;
        foreach (kind_cnt[k]) kind_cnt[k] = 0;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int p = 2; p < 8; p++) key_pool[p] = KEY_W'($urandom);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty list, extremes, duplicates, gap closing, bad positions.
        send_req(make_req(REQ_READ,   '0,       '0,           '0));
        send_req(make_req(REQ_FIND,   '0,       '0,           '0));
        send_req(make_req(REQ_REMOVE, '1,       '0,           '0));
        send_req(make_req(REQ_APPEND, '0,       '0,           '0));
        send_req(make_req(REQ_APPEND, '1,       '1,           '1));
        send_req(make_req(REQ_APPEND, 16'h1234, 32'hA5A5_A5A5, '0));
        send_req(make_req(REQ_APPEND, 16'h1234, 32'h5A5A_5A5A, '0));
        send_req(make_req(REQ_APPEND, 16'h8001, 32'h0000_0001, '0));
        send_req(make_req(REQ_FIND,   16'h1234, '0,           '0));
        send_req(make_req(REQ_FIND,   16'h4321, '0,           '0));
        send_req(make_req(REQ_READ,   '0,       '0,           6'd3));
        send_req(make_req(REQ_READ,   '0,       '0,           6'd5));
        send_req(make_req(REQ_READ,   '0,       '0,           '1));
        send_req(make_req(REQ_REMOVE, 16'h1234, '0,           '0));
        send_req(make_req(REQ_FIND,   16'h1234, '0,           '0));
        send_req(make_req(REQ_READ,   '0,       '0,           6'd2));
        send_req(make_req(REQ_REMOVE, '0,       '0,           '0));
        send_req(make_req(REQ_REMOVE, 16'h8001, '0,           '0));
        send_req(make_req(REQ_REMOVE, 16'h7777, '0,           '0));
        send_req(make_req(REQ_READ,   '0,       '0,           '0));
        send_req(make_req(REQ_REMOVE, '1,       '0,           '0));
        send_req(make_req(REQ_REMOVE, 16'h1234, '0,           '0));
        send_req(make_req(REQ_READ,   '0,       '0,           '0));

        // Random: three idle patterns, each a run of grow, shrink and mixed segments.
        for (phase = 0; phase < 3; phase++) begin
            wait_idle();
            case (phase)
                0: begin
                    send_idle_pct = 13;
                    recv_idle_pct = 73;
                end
                1: begin
                    send_idle_pct = 73;
                    recv_idle_pct = 13;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            phase_items = 0;
            if (phase != 1) begin
                // Fill past capacity so appends hit a full list, then read deep.
                repeat (CAPACITY + 2)
                    send_req(make_req(REQ_APPEND, pick_key(), DATA_W'($urandom), '0));
                repeat (6) send_req(make_req(REQ_READ, '0, '0, POS_W'($urandom)));
                send_req(make_req(REQ_READ, '0, '0, '1));
                phase_items = CAPACITY + 9;
            end
            while (phase_items < PHASE_ITEMS) begin
                seg_mode = $urandom_range(2);
                seg_len  = $urandom_range(10, 40);
                repeat (seg_len) begin
                    case (seg_mode)
                        0:       send_mix(55, 15, 15);
                        1:       send_mix(15, 50, 15);
                        default: send_mix(30, 25, 20);
                    endcase
                end
                phase_items += seg_len;
                // Now and then let the block drain completely before going on.
                if ($urandom_range(4) == 0) wait_idle();
            end
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests: %0d append, %0d remove, %0d find, %0d read",
                 kind_cnt[REQ_APPEND] + kind_cnt[REQ_REMOVE] + kind_cnt[REQ_FIND]
                 + kind_cnt[REQ_READ], kind_cnt[REQ_APPEND], kind_cnt[REQ_REMOVE],
                 kind_cnt[REQ_FIND], kind_cnt[REQ_READ]);
        $display("Checked %0d responses under three stall patterns, %0d mismatches",
                 checked_cnt, error_cnt);
        if (error_cnt == 0 && pending_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[files.f]
src/okl_pkg.sv
src/okl_ifs.sv
src/okl_store.sv
src/ordered_keyed_list.sv
bench/okl_checker.sv
bench/ordered_keyed_list_tb.sv
